/* src/rkht_pkg.sv */
`timescale 1ns / 1ps
package rkht_pkg;
   localparam int unsigned ENTRIES   = 64;
   localparam int unsigned SLOT_BITS = 6;
   localparam int unsigned IDX_BITS  = $clog2(ENTRIES);
   localparam int unsigned CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int unsigned REF_BITS  = 16;
   localparam int unsigned FLAG_BITS = 8;
   localparam int unsigned HASH_BITS = 32;
   localparam logic [HASH_BITS-1:0] HASH_SEED = 32'h5555_5555;
   localparam logic [REF_BITS-1:0]  REF_MAX   = '1;
   localparam logic [FLAG_BITS-1:0] DIRTY_RESET = 8'd1;

   typedef enum logic [1:0] {
      KIND_GET  = 2'd0,
      KIND_PUT  = 2'd1,
      KIND_TEST = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_INSERTED = 3'd1,
      ST_RELEASED = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_IGNORED  = 3'd4,
      ST_FULL     = 3'd5,
      ST_ANSWERED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_SCAN_CHK,
      FSM_SLOT_RD,
      FSM_SLOT_CHK,
      FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic [HASH_BITS-1:0] key_hash;
      logic [REF_BITS-1:0]  refs;
      logic [FLAG_BITS-1:0] flags;
   } entry_type;

   function automatic logic [HASH_BITS-1:0] fold_byte(input logic [HASH_BITS-1:0] h,
                                                     input logic [7:0] b);
      logic [HASH_BITS-1:0] t;
      t = h ^ (h << 16);
      t = t ^ {{(HASH_BITS-8){1'b0}}, b};
      return {t[HASH_BITS-9:0], t[HASH_BITS-1:HASH_BITS-8]};
   endfunction
endpackage

/* src/rkht_if.sv */
`timescale 1ns / 1ps
interface rkht_req_if;
   import rkht_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [7:0] key_byte;
   logic has_byte;
   logic key_last;
   logic [FLAG_BITS-1:0] set_flags;
   logic [SLOT_BITS-1:0] slot;
   modport source (output valid, kind, key_byte, has_byte, key_last, set_flags, slot,
                   input ready);
   modport sink (input valid, kind, key_byte, has_byte, key_last, set_flags, slot,
                 output ready);
endinterface

interface rkht_rsp_if;
   import rkht_pkg::*;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic [SLOT_BITS-1:0] entry_slot;
   logic [HASH_BITS-1:0] key_hash;
   logic [REF_BITS-1:0] ref_count;
   logic [FLAG_BITS-1:0] entry_flags;
   logic dirty;
   logic [CNT_BITS-1:0] entries_used;
   modport source (output valid, status, entry_slot, key_hash, ref_count, entry_flags,
                   dirty, entries_used, input ready);
   modport sink (input valid, status, entry_slot, key_hash, ref_count, entry_flags,
                 dirty, entries_used, output ready);
endinterface

/* src/rkht_entry_ram.sv */
`timescale 1ns / 1ps
module rkht_entry_ram
   import rkht_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_BITS-1:0] wr_addr,
   input  entry_type           wr_data,
   input  logic [IDX_BITS-1:0] rd_addr,
   output entry_type           rd_data
);
   entry_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* src/refcounted_key_hash_table.sv */
`timescale 1ns / 1ps
// Reference-counted key table.
// req channel: one beat per key byte (kind get), or one beat per put/test
// on a slot. Key bytes fold into a running hash, one beat a cycle, no result.
// The beat carrying key_last starts a lookup: the entry memory is walked in
// slot order (one read port, registered data), skipping free entries and
// reading, then comparing, each valid one. A hit stops the walk early; a
// walk with no hit inserts at the lowest free entry, or reports full.
// Put and test read the slot and check it; a put writes the lowered count
// back. Kind 3 beats are dropped.
// rsp channel: one beat per get end, put or test, from an output register.
// One beat in flight at a time; req ready is low while a lookup or slot
// access is in flight or a result waits, so a stalled receiver holds the
// input side off with the result stable.
// Reset (synchronous): hash back to the seed, all entries free, used count
// zero, dirty_mask back to 1. Entry contents need no clearing: per-entry
// valid bits in flops mark what may be read.
// csr: csr_we writes dirty_mask; applied to results as they are shown.
module refcounted_key_hash_table
   import rkht_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   rkht_req_if.sink             req,
   rkht_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [FLAG_BITS-1:0] csr_wdata
);
   fsm_type state_ff, state_in;
   logic [HASH_BITS-1:0] acc_ff, acc_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_BITS-1:0] used_ff, used_in;
   logic [FLAG_BITS-1:0] mask_ff;
   logic [CNT_BITS-1:0] idx_ff, idx_in;       // scan position, can reach ENTRIES
   logic [HASH_BITS-1:0] look_ff, look_in;
   logic [FLAG_BITS-1:0] setf_ff, setf_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic put_ff, put_in;
   // result register
   logic [2:0] st_ff, st_in;
   logic [SLOT_BITS-1:0] oslot_ff, oslot_in;
   entry_type oent_ff, oent_in;

   logic wr_en;
   logic [IDX_BITS-1:0] wr_addr, rd_addr;
   entry_type wr_data, rd_data;

   rkht_entry_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic [IDX_BITS-1:0] free_idx;
   logic any_free;
   logic slot_in_range;
   logic [IDX_BITS-1:0] cur_idx, slot_idx;

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_BITS'(i);
            any_free = 1'b1;
         end
      end
   end

   assign cur_idx = idx_ff[IDX_BITS-1:0];
   assign slot_in_range = ({{(CNT_BITS > SLOT_BITS ? CNT_BITS-SLOT_BITS : 0){1'b0}},
                            slot_ff} < CNT_BITS'(ENTRIES));
   assign slot_idx = IDX_BITS'(slot_ff);

   assign req.ready = (state_ff == FSM_IDLE);
   assign rsp.valid = (state_ff == FSM_OUT);
   assign rsp.status = st_ff;
   assign rsp.entry_slot = oslot_ff;
   assign rsp.key_hash = oent_ff.key_hash;
   assign rsp.ref_count = oent_ff.refs;
   assign rsp.entry_flags = oent_ff.flags;
   assign rsp.dirty = |(oent_ff.flags & mask_ff);
   assign rsp.entries_used = used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         acc_ff <= HASH_SEED;
         valid_ff <= '0;
         used_ff <= '0;
         mask_ff <= DIRTY_RESET;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         valid_ff <= valid_in;
         used_ff <= used_in;
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      look_ff <= look_in;
      setf_ff <= setf_in;
      slot_ff <= slot_in;
      put_ff <= put_in;
      st_ff <= st_in;
      oslot_ff <= oslot_in;
      oent_ff <= oent_in;
   end

   always_comb begin
      logic [HASH_BITS-1:0] h;
      entry_type e;
      state_in = state_ff;
      acc_in = acc_ff;
      valid_in = valid_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      look_in = look_ff;
      setf_in = setf_ff;
      slot_in = slot_ff;
      put_in = put_ff;
      st_in = st_ff;
      oslot_in = oslot_ff;
      oent_in = oent_ff;
      wr_en = 1'b0;
      wr_addr = cur_idx;
      wr_data = rd_data;
      rd_addr = cur_idx;
      h = acc_ff;
      e = rd_data;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req.valid) begin
               unique case (kind_type'(req.kind))
                  KIND_GET: begin
                     h = req.has_byte ? fold_byte(acc_ff, req.key_byte) : acc_ff;
                     if (req.key_last) begin
                        acc_in = HASH_SEED;
                        look_in = h;
                        setf_in = req.set_flags;
                        idx_in = '0;
                        state_in = FSM_SCAN;
                     end else begin
                        acc_in = h;
                     end
                  end
                  KIND_PUT, KIND_TEST: begin
                     slot_in = req.slot;
                     put_in = (kind_type'(req.kind) == KIND_PUT);
                     state_in = FSM_SLOT_RD;
                  end
                  default: ;
               endcase
            end
         end
         FSM_SCAN: begin
            // skip free entries and read the next valid one; past the last, insert or report full
            if (idx_ff == CNT_BITS'(ENTRIES)) begin
               if (any_free) begin
                  wr_en = 1'b1;
                  wr_addr = free_idx;
                  wr_data = '{key_hash: look_ff, refs: REF_BITS'(1), flags: setf_ff};
                  valid_in[free_idx] = 1'b1;
                  used_in = used_ff + CNT_BITS'(1);
                  st_in = ST_INSERTED;
                  oslot_in = SLOT_BITS'(free_idx);
                  oent_in = wr_data;
               end else begin
                  st_in = ST_FULL;
                  oslot_in = '0;
                  oent_in = '{key_hash: look_ff, refs: '0, flags: '0};
               end
               state_in = FSM_OUT;
            end else if (valid_ff[cur_idx]) begin
               state_in = FSM_SCAN_CHK;
            end else begin
               idx_in = idx_ff + CNT_BITS'(1);
            end
         end
         FSM_SCAN_CHK: begin
            if (e.key_hash == look_ff) begin
               if (e.refs != REF_MAX) begin
                  e.refs = e.refs + REF_BITS'(1);
               end
               e.flags = e.flags | setf_ff;
               wr_en = 1'b1;
               wr_data = e;
               st_in = ST_HIT;
               oslot_in = SLOT_BITS'(cur_idx);
               oent_in = e;
               state_in = FSM_OUT;
            end else begin
               idx_in = idx_ff + CNT_BITS'(1);
               state_in = FSM_SCAN;
            end
         end
         FSM_SLOT_RD: begin
            rd_addr = slot_idx;
            state_in = FSM_SLOT_CHK;
         end
         FSM_SLOT_CHK: begin
            oslot_in = slot_ff;
            wr_addr = slot_idx;
            if (!slot_in_range || !valid_ff[slot_idx]) begin
               st_in = put_ff ? ST_IGNORED : ST_ANSWERED;
               oent_in = '0;
            end else if (!put_ff) begin
               st_in = ST_ANSWERED;
               oent_in = e;
            end else if (e.refs == '0) begin
               st_in = ST_IGNORED;
               oent_in = e;
            end else begin
               e.refs = e.refs - REF_BITS'(1);
               wr_en = 1'b1;
               wr_data = e;
               oent_in = e;
               if (e.refs == '0) begin
                  st_in = ST_REMOVED;
                  valid_in[slot_idx] = 1'b0;
                  if (used_ff != '0) begin
                     used_in = used_ff - CNT_BITS'(1);
                  end
               end else begin
                  st_in = ST_RELEASED;
               end
            end
            state_in = FSM_OUT;
         end
         FSM_OUT: begin
            if (rsp.ready) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end
endmodule

/* src/rkht_checker.sv */
`timescale 1ns / 1ps
module rkht_checker
   import rkht_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_status,
   input logic [REF_BITS-1:0] rsp_ref_count,
   input logic [CNT_BITS-1:0] rsp_entries_used
);
   // one beat in flight: no input taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken with result pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped under stall");

   a_insert_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |-> rsp_ref_count == REF_BITS'(1)
      && rsp_entries_used != '0) else $error("insert count wrong");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_REMOVED |-> rsp_ref_count == '0)
      else $error("removed with references");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      rsp_entries_used <= CNT_BITS'(ENTRIES)) else $error("used count overflow");
endmodule

bind refcounted_key_hash_table rkht_checker u_rkht_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_ref_count(rsp.ref_count),
   .rsp_entries_used(rsp.entries_used)
);

/* dv/refcounted_key_hash_table_tb.sv */
`timescale 1ns / 1ps
module refcounted_key_hash_table_tb;
   import rkht_pkg::*;

   // request beat as the sender sees it
   typedef struct {
      kind_type             kind;
      logic [7:0]           key_byte;
      logic                 has_byte;
      logic                 key_last;
      logic [FLAG_BITS-1:0] set_flags;
      logic [SLOT_BITS-1:0] slot;
   } req_beat_t;

   // one result beat
   typedef struct {
      status_type           status;
      logic [SLOT_BITS-1:0] entry_slot;
      logic [HASH_BITS-1:0] key_hash;
      logic [REF_BITS-1:0]  ref_count;
      logic [FLAG_BITS-1:0] entry_flags;
      logic                 dirty;
      logic [CNT_BITS-1:0]  entries_used;
   } rsp_beat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [FLAG_BITS-1:0] csr_wdata = '0;

   rkht_req_if req ();
   rkht_rsp_if rsp ();

   refcounted_key_hash_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---- table shadow: own copy of the state the block keeps ----
   logic [HASH_BITS-1:0] tbl_acc;
   logic                 tbl_valid [ENTRIES];
   logic [HASH_BITS-1:0] tbl_hash  [ENTRIES];
   logic [REF_BITS-1:0]  tbl_refs  [ENTRIES];
   logic [FLAG_BITS-1:0] tbl_flags [ENTRIES];
   logic [CNT_BITS-1:0]  tbl_used;
   logic [FLAG_BITS-1:0] tbl_dirty_mask;

   rsp_beat_t expected_rsps [$];
   int unsigned n_errors = 0;
   int unsigned cycle_count = 0;
   bit rx_hold = 1'b0;        // long receiver hold-off in progress
   bit rx_random = 1'b1;      // receiver draws random stalls
   bit tx_random = 1'b1;      // sender draws random gaps

   // hash fold: xor with self shifted 16, xor byte, rotate left 8
   function automatic logic [HASH_BITS-1:0] hash_step(logic [HASH_BITS-1:0] h,
                                                     logic [7:0] b);
      logic [HASH_BITS-1:0] t;
      t = h ^ {h[15:0], 16'h0000};
      t[7:0] = t[7:0] ^ b;
      return {t[23:0], t[31:24]};
   endfunction

   function automatic rsp_beat_t make_rsp(status_type st, logic [SLOT_BITS-1:0] s,
                                          logic [HASH_BITS-1:0] h,
                                          logic [REF_BITS-1:0] r,
                                          logic [FLAG_BITS-1:0] f);
      rsp_beat_t o;
      o.status = st;
      o.entry_slot = s;
      o.key_hash = h;
      o.ref_count = r;
      o.entry_flags = f;
      o.dirty = |(f & tbl_dirty_mask);
      o.entries_used = tbl_used;
      return o;
   endfunction

   function automatic void table_reset();
      tbl_acc = HASH_SEED;
      tbl_used = '0;
      tbl_dirty_mask = DIRTY_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_hash[i] = '0;
         tbl_refs[i] = '0;
         tbl_flags[i] = '0;
      end
   endfunction

   // work out the result of one accepted beat and queue it
   function automatic void table_apply(req_beat_t b);
      logic [HASH_BITS-1:0] h;
      int s;
      bit done;
      s = int'(b.slot);
      done = 0;
      case (b.kind)
         KIND_GET: begin
            if (b.has_byte) tbl_acc = hash_step(tbl_acc, b.key_byte);
            if (b.key_last) begin
               h = tbl_acc;
               tbl_acc = HASH_SEED;
               for (int i = 0; i < ENTRIES && !done; i++)
                  if (tbl_valid[i] && tbl_hash[i] == h) begin
                     if (tbl_refs[i] != REF_MAX) tbl_refs[i]++;
                     tbl_flags[i] |= b.set_flags;
                     expected_rsps.push_back(make_rsp(ST_HIT, SLOT_BITS'(i), h,
                                                      tbl_refs[i], tbl_flags[i]));
                     done = 1;
                  end
               for (int i = 0; i < ENTRIES && !done; i++)
                  if (!tbl_valid[i]) begin
                     tbl_valid[i] = 1'b1;
                     tbl_hash[i] = h;
                     tbl_refs[i] = REF_BITS'(1);
                     tbl_flags[i] = b.set_flags;
                     tbl_used++;
                     expected_rsps.push_back(make_rsp(ST_INSERTED, SLOT_BITS'(i), h,
                                                      REF_BITS'(1), b.set_flags));
                     done = 1;
                  end
               if (!done) expected_rsps.push_back(make_rsp(ST_FULL, '0, h, '0, '0));
            end
         end
         KIND_PUT: begin
            if (!tbl_valid[s])
               expected_rsps.push_back(make_rsp(ST_IGNORED, b.slot, '0, '0, '0));
            else if (tbl_refs[s] == 0)
               expected_rsps.push_back(make_rsp(ST_IGNORED, b.slot, tbl_hash[s], '0,
                                                tbl_flags[s]));
            else begin
               tbl_refs[s]--;
               if (tbl_refs[s] == 0) begin
                  tbl_valid[s] = 1'b0;
                  if (tbl_used != 0) tbl_used--;
                  expected_rsps.push_back(make_rsp(ST_REMOVED, b.slot, tbl_hash[s], '0,
                                                   tbl_flags[s]));
               end else
                  expected_rsps.push_back(make_rsp(ST_RELEASED, b.slot, tbl_hash[s],
                                                   tbl_refs[s], tbl_flags[s]));
            end
         end
         KIND_TEST: begin
            if (!tbl_valid[s])
               expected_rsps.push_back(make_rsp(ST_ANSWERED, b.slot, '0, '0, '0));
            else
               expected_rsps.push_back(make_rsp(ST_ANSWERED, b.slot, tbl_hash[s],
                                                tbl_refs[s], tbl_flags[s]));
         end
         default: ;   // unused kind: dropped, nothing comes back
      endcase
   endfunction

   // ---- sender ----
   initial begin
      req.valid = 1'b0;
      req.kind = KIND_GET;
      req.key_byte = '0;
      req.has_byte = 1'b0;
      req.key_last = 1'b0;
      req.set_flags = '0;
      req.slot = '0;
   end

   // drive one beat, wait for its acceptance, then update the shadow; valid
   // stays up after acceptance until the next call (same step) replaces the
   // beat or lowers valid for a gap, so valid gets one assignment per step
   task automatic send_beat(req_beat_t b);
      int gap;
      gap = tx_random ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= b.kind;
      req.key_byte <= b.key_byte;
      req.has_byte <= b.has_byte;
      req.key_last <= b.key_last;
      req.set_flags <= b.set_flags;
      req.slot <= b.slot;
      do @(posedge clock); while (!req.ready);
      table_apply(b);
   endtask

   function automatic req_beat_t beat(kind_type k, logic [7:0] kb, logic hb, logic kl,
                                      logic [FLAG_BITS-1:0] f, logic [SLOT_BITS-1:0] s);
      req_beat_t b;
      b.kind = k; b.key_byte = kb; b.has_byte = hb; b.key_last = kl;
      b.set_flags = f; b.slot = s;
      return b;
   endfunction

   // a whole get: n bytes, the last carrying the key end (a bare end when n is 0)
   task automatic send_key(int n, logic [7:0] base, logic [FLAG_BITS-1:0] f);
      for (int i = 0; i < n; i++)
         send_beat(beat(KIND_GET, base + i[7:0], 1'b1, i == n - 1, f,
                        SLOT_BITS'($urandom)));
      if (n == 0) send_beat(beat(KIND_GET, 8'($urandom), 1'b0, 1'b1, f,
                                 SLOT_BITS'($urandom)));
   endtask

   // idle the sender, wait for every result, then let the block settle
   task automatic drain();
      int guard;
      guard = 0;
      if (req.valid) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      while (expected_rsps.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic write_dirty_mask(logic [FLAG_BITS-1:0] m);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      tbl_dirty_mask = m;
   endtask

   // ---- receiver ----
   initial rsp.ready = 1'b0;

   always @(posedge clock) begin
      if (reset || rx_hold) begin
         rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready || !rsp.ready) begin
         // fresh draw after each beat taken and while stalled
         rsp.ready <= rx_random ? ($urandom_range(0, 11) == 0) : 1'b1;
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_beat_t e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("result beat with nothing expected (status %0d)", rsp.status);
            n_errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp.status); n_errors++;
            end
            if (rsp.entry_slot !== e.entry_slot) begin
               $error("entry_slot exp %0d got %0d", e.entry_slot, rsp.entry_slot);
               n_errors++;
            end
            if (rsp.key_hash !== e.key_hash) begin
               $error("key_hash exp %h got %h", e.key_hash, rsp.key_hash); n_errors++;
            end
            if (rsp.ref_count !== e.ref_count) begin
               $error("ref_count exp %0d got %0d", e.ref_count, rsp.ref_count);
               n_errors++;
            end
            if (rsp.entry_flags !== e.entry_flags) begin
               $error("entry_flags exp %h got %h", e.entry_flags, rsp.entry_flags);
               n_errors++;
            end
            if (rsp.dirty !== e.dirty) begin
               $error("dirty exp %0d got %0d", e.dirty, rsp.dirty); n_errors++;
            end
            if (rsp.entries_used !== e.entries_used) begin
               $error("entries_used exp %0d got %0d", e.entries_used, rsp.entries_used);
               n_errors++;
            end
         end
      end
   end

   // watchdog: slowest run is far below this
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 3000000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---- tests ----

   // field extremes, empty key, unused kind, interleaving, puts/tests
   task automatic test_directed();
      send_key(0, 8'h00, 8'hFF);                              // empty key: insert
      send_key(0, 8'h00, 8'h00);                              // empty key again: hit
      send_beat(beat(KIND_GET, 8'hFF, 1'b1, 1'b0, 8'h00, 6'h3F)); // part of a key
      send_beat(beat(KIND_TEST, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0)); // interleaved test
      send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00, 6'h3F)); // put on free slot
      send_beat(beat(KIND_NONE, 8'hAA, 1'b1, 1'b1, 8'hFF, 6'd1)); // unused kind
      send_beat(beat(KIND_GET, 8'h00, 1'b1, 1'b1, 8'h80, 6'd0));  // finish the key
      send_beat(beat(KIND_GET, 8'h5A, 1'b0, 1'b0, 8'h00, 6'd0));  // no byte, no end
      send_beat(beat(KIND_TEST, 8'h00, 1'b0, 1'b0, 8'h00, 6'd1));
      send_beat(beat(KIND_TEST, 8'h00, 1'b0, 1'b0, 8'h00, 6'h3F)); // test on free slot
      send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0));  // released
      send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0));  // removed
      send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0));  // now ignored
      send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00, 6'd1));  // removed
      send_key(3, 8'h10, 8'h01);
      send_key(3, 8'h10, 8'h02);                               // same key: hit
   endtask

   // fill all entries, the keys beyond that report full, then empty the table
   task automatic test_table_full();
      drain();
      for (int i = 0; i < ENTRIES + 2; i++)
         send_key(2, i[7:0] * 8'd3, FLAG_BITS'($urandom));
      for (int i = 0; i < ENTRIES; i++)
         while (tbl_valid[i]) send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00,
                                             SLOT_BITS'(i)));
   endtask

   // many hits on one key build up its count, then a put brings it down
   task automatic test_repeat_hits();
      tx_random = 1'b0;
      rx_random = 1'b0;
      for (int i = 0; i < 100; i++)
         send_beat(beat(KIND_GET, 8'hC3, 1'b1, 1'b1, i[7:0], 6'd0));
      drain();
      tx_random = 1'b1;
      rx_random = 1'b1;
      send_beat(beat(KIND_PUT, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0));
      send_key(1, 8'hC3, 8'h00);
      send_beat(beat(KIND_TEST, 8'h00, 1'b0, 1'b0, 8'h00, 6'd0));
   endtask

   // receiver held off long while the sender keeps going
   task automatic test_backpressure();
      drain();
      tx_random = 1'b0;
      fork
         begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clock);
            rx_hold = 1'b0;
         end
         for (int i = 0; i < 30; i++)
            send_beat(beat(KIND_TEST, 8'h00, 1'b0, 1'b0, 8'h00, SLOT_BITS'($urandom)));
      join
      tx_random = 1'b1;
   endtask

   // mostly well-formed gets over a small key space, plus puts, tests and noise
   task automatic test_random(int n_items);
      int sent;
      int r;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            r = $urandom_range(0, 3);
            send_key(r, 8'($urandom_range(0, 5)) * 8'd17, FLAG_BITS'($urandom));
            sent += r == 0 ? 1 : r;
         end else if (r < 75) begin
            send_beat(beat(KIND_PUT, 8'($urandom), 1'($urandom), 1'($urandom),
                           FLAG_BITS'($urandom), SLOT_BITS'($urandom_range(0, 15))));
            sent++;
         end else if (r < 90) begin
            send_beat(beat(KIND_TEST, 8'($urandom), 1'($urandom), 1'($urandom),
                           FLAG_BITS'($urandom), SLOT_BITS'($urandom)));
            sent++;
         end else begin
            // raw beats: stray bytes, empty ends, unused kind
            send_beat(beat(kind_type'($urandom_range(0, 3)), 8'($urandom),
                           1'($urandom), 1'($urandom), FLAG_BITS'($urandom),
                           SLOT_BITS'($urandom)));
            sent++;
         end
      end
   endtask

   initial begin
      table_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      write_dirty_mask(8'h00);
      test_random(250);
      write_dirty_mask(8'hFF);
      test_repeat_hits();
      test_backpressure();
      write_dirty_mask(8'h81);
      test_random(350);
      write_dirty_mask(FLAG_BITS'($urandom));
      test_random(350);
      drain();
      if (n_errors == 0 && expected_rsps.size() == 0) begin
         $display("SUCCESS");
      end else begin
         if (expected_rsps.size() != 0)
            $error("%0d expected results never came", expected_rsps.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
